### rtl/assert_macros.svh
// assertion macros used by graph_reachability_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/grt_pkg.sv
// package for the graph reachability table: types, constants, helpers
package grt_pkg;

  localparam int NodeCount     = 256;
  localparam int MaxNeighbours = 10;
  localparam int NodeW         = $clog2(NodeCount);
  localparam int CntW          = $clog2(MaxNeighbours + 1);
  localparam int SlotW         = $clog2(MaxNeighbours);
  localparam int TblDepth      = NodeCount * MaxNeighbours;
  localparam int TblAw         = $clog2(TblDepth);
  localparam int SpW           = $clog2(NodeCount + 1);

  typedef enum logic [2:0] {
    MODE_CREATE = 3'd0,
    MODE_LINK   = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_FLAG   = 3'd3,
    MODE_ROUTE  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] node_a;
    logic [7:0] node_b;
    logic [2:0] bit_position;
    logic       bit_value;
    logic [7:0] flag_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       route_exists;
    logic [7:0] flag_out;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,   // clearing pass over the node memory after reset
    S_IDLE,
    S_RD,      // node record read issued
    S_EXEC,    // node record available
    S_VCLR,    // clearing visited marks, node_a's mark set
    S_POP,
    S_POPWT,
    S_NODE,    // popped node record available
    S_NBRD,    // slot read issued
    S_NBCHK,   // slot data available, read its node record
    S_NBEVAL,
    S_DONE,
    S_OUT
  } state_e;

  // node record kept in the node memory
  typedef struct packed {
    logic            present;
    logic [7:0]      flags;
    logic [CntW-1:0] count;
  } node_rec_t;

  // request from the controller to the walk memories
  typedef struct packed {
    logic             vis_we;
    logic [NodeW-1:0] vis_addr;
    logic             vis_wd;
    logic             stk_we;
    logic [NodeW-1:0] stk_addr;
    logic [NodeW-1:0] stk_wd;
  } walk_req_t;

  function automatic logic [TblAw-1:0] slot_addr(logic [NodeW-1:0] n,
                                                 logic [SlotW-1:0] k);
    logic [TblAw-1:0] base;
    base = TblAw'(n) * TblAw'(MaxNeighbours);
    return base + TblAw'(k);
  endfunction

endpackage

### rtl/graph_reachability_table.sv
// One item at a time. Create, link, delete and flag operations read the node
// record, then write it back and give the result. A route query first clears
// the visited map over all NodeCount entries, then walks depth first: each
// popped node passes S_POP, S_POPWT, S_NODE and S_NBRD, and each neighbour
// slot S_NBRD, S_NBCHK and S_NBEVAL, as set by the single read port
// of the node and neighbour memories. After reset a clearing pass over all
// NodeCount entries of the node memory runs before the first item is taken.
// The result is held in an output register until taken.
module graph_reachability_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  grt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output grt_pkg::out_item_t out_data_o
);
  import grt_pkg::*;
  `include "assert_macros.svh"

  state_e state_q, state_d;
  in_item_t item_q;
  logic [NodeW-1:0] idx_q, idx_d;       // clear index / current node
  logic [SpW-1:0]   sp_q, sp_d;
  logic [CntW-1:0]  k_q, k_d, cnt_q, cnt_d;
  logic [NodeW-1:0] nb_q, nb_d;
  logic [1:0]       st_q, st_d;
  logic             route_q, route_d;
  out_item_t        out_q;
  logic             out_vld_q;

  // node memory port
  logic             nd_we;
  logic [NodeW-1:0] nd_addr;
  node_rec_t        nd_wd, nd_rd;
  // neighbour table port
  logic             tb_we;
  logic [TblAw-1:0] tb_addr;
  logic [NodeW-1:0] tb_wd, tb_rd;
  walk_req_t        wreq;
  logic             vis_rd;
  logic [NodeW-1:0] stk_rd;

  grt_ram #(.Depth(NodeCount), .Width($bits(node_rec_t))) u_node (
    .clk_i, .we_i(nd_we), .addr_i(nd_addr), .wdata_i(nd_wd), .rdata_o(nd_rd));
  grt_ram #(.Depth(TblDepth), .Width(NodeW)) u_tbl (
    .clk_i, .we_i(tb_we), .addr_i(tb_addr), .wdata_i(tb_wd), .rdata_o(tb_rd));
  grt_walk_mem u_walk (.clk_i, .req_i(wreq), .vis_rd_o(vis_rd), .stk_rd_o(stk_rd));

  logic a_in, b_in;
  assign a_in = ({24'd0, item_q.node_a} < NodeCount);
  assign b_in = ({24'd0, item_q.node_b} < NodeCount);

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  logic out_free;
  assign out_free = !out_vld_q || !out_stall_i;

  logic [NodeW-1:0] a_n, b_n;
  assign a_n = item_q.node_a[NodeW-1:0];
  assign b_n = item_q.node_b[NodeW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (idx_q == NodeW'(NodeCount - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_acc) state_d = S_RD;
      S_RD:     state_d = (item_q.mode == MODE_ROUTE) ? S_VCLR : S_EXEC;
      S_EXEC:   state_d = S_OUT;
      S_VCLR:   if (idx_q == NodeW'(NodeCount - 1))
                  state_d = (st_q != ST_OK) ? S_OUT : S_POP;
      S_POP:    state_d = (sp_q == '0) ? S_DONE : S_POPWT;
      S_POPWT:  state_d = S_NODE;
      S_NODE:   state_d = S_NBRD;
      S_NBRD:   state_d = (k_q >= cnt_q) ? S_POP : S_NBCHK;
      S_NBCHK:  state_d = S_NBEVAL;
      S_NBEVAL: state_d = S_NBRD;
      S_DONE:   state_d = S_OUT;
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    nd_we = 1'b0; nd_addr = a_n; nd_wd = nd_rd;
    tb_we = 1'b0; tb_addr = slot_addr(idx_q, k_q[SlotW-1:0]);
    tb_wd = item_q.node_b[NodeW-1:0];
    wreq = '0;
    wreq.vis_addr = idx_q;
    wreq.stk_addr = sp_q[NodeW-1:0];
    idx_d = idx_q; sp_d = sp_q; k_d = k_q; cnt_d = cnt_q; nb_d = nb_q;
    st_d = st_q; route_d = route_q;
    unique case (state_q)
      S_CLEAR: begin
        nd_we = 1'b1; nd_addr = idx_q; nd_wd = '0;
        idx_d = idx_q + 1'b1;
      end
      S_IDLE: begin
        st_d = ST_OK; route_d = 1'b0; idx_d = '0;
        nd_addr = in_data_i.node_a[NodeW-1:0];
      end
      S_RD: begin
        // keep node_a on the port so its record is seen in S_EXEC or S_VCLR
        nd_addr = a_n;
      end
      S_EXEC: begin
        unique case (item_q.mode)
          MODE_CREATE: begin
            if (a_in) begin
              nd_we = 1'b1;
              nd_wd = '{present: 1'b1, flags: item_q.flag_byte, count: '0};
            end else st_d = ST_ABSENT;
          end
          MODE_LINK: begin
            if (!a_in || !nd_rd.present) st_d = ST_ABSENT;
            else if (nd_rd.count >= CntW'(MaxNeighbours)) st_d = ST_FULL;
            else begin
              nd_we = 1'b1; nd_wd.count = nd_rd.count + 1'b1;
              tb_we = 1'b1; tb_addr = slot_addr(a_n, nd_rd.count[SlotW-1:0]);
            end
          end
          MODE_DELETE: begin
            if (!a_in || !nd_rd.present) st_d = ST_ABSENT;
            else begin nd_we = 1'b1; nd_wd.present = 1'b0; end
          end
          MODE_FLAG: begin
            if (!a_in || !nd_rd.present) st_d = ST_ABSENT;
            else begin
              nd_we = 1'b1;
              nd_wd.flags[item_q.bit_position] = item_q.bit_value;
            end
          end
          default: ;
        endcase
      end
      S_VCLR: begin
        wreq.vis_we = 1'b1;
        wreq.vis_wd = (idx_q == a_n);
        if (idx_q == '0) begin
          // node_a record arrived last cycle is in nd_rd at S_VCLR entry
          if (!a_in || !nd_rd.present) st_d = ST_ABSENT;
        end
        if (idx_q == NodeW'(1)) begin
          if (!b_in || !nd_rd.present) st_d = ST_ABSENT;
        end
        if (idx_q == NodeW'(NodeCount - 1)) begin
          wreq.stk_we = 1'b1; wreq.stk_addr = '0; wreq.stk_wd = a_n;
          sp_d = SpW'(1);
        end
        idx_d = idx_q + 1'b1;
        nd_addr = b_n;
      end
      S_POP: begin
        if (sp_q != '0) begin
          sp_d = sp_q - 1'b1;
          wreq.stk_addr = NodeW'(sp_q - 1'b1);
        end else begin
          wreq.vis_addr = b_n;
        end
      end
      S_POPWT: begin
        nd_addr = stk_rd; idx_d = stk_rd; k_d = '0;
      end
      S_NODE: begin
        cnt_d = (nd_rd.count > CntW'(MaxNeighbours)) ? CntW'(MaxNeighbours)
                                                    : nd_rd.count;
      end
      S_NBRD: ; // table address from idx_q and k_q
      S_NBCHK: begin
        nb_d = tb_rd; nd_addr = tb_rd; wreq.vis_addr = tb_rd;
      end
      S_NBEVAL: begin
        wreq.vis_addr = nb_q;
        k_d = k_q + 1'b1;
        if (nd_rd.present && !vis_rd) begin
          wreq.vis_we = 1'b1; wreq.vis_wd = 1'b1;
          if (sp_q < SpW'(NodeCount)) begin
            wreq.stk_we = 1'b1; wreq.stk_addr = sp_q[NodeW-1:0];
            wreq.stk_wd = nb_q; sp_d = sp_q + 1'b1;
          end
        end
      end
      S_DONE: route_d = vis_rd;
      S_OUT: nd_addr = a_n;
      default: ;
    endcase
  end

  // node_a flags after the operation, captured in S_EXEC or at S_VCLR entry
  logic [7:0] flag_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; idx_q <= '0; sp_q <= '0; out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; sp_q <= sp_d;
      out_vld_q <= (state_q == S_OUT && out_free) || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    k_q <= k_d; cnt_q <= cnt_d; nb_q <= nb_d; st_q <= st_d; route_q <= route_d;
    if (state_q == S_EXEC) flag_q <= nd_we ? nd_wd.flags : nd_rd.flags;
    if (state_q == S_VCLR && idx_q == '0) flag_q <= nd_rd.flags;
    if (state_q == S_OUT && out_free) begin
      out_q.status       <= st_q;
      out_q.route_exists <= route_q & (st_q == ST_OK);
      out_q.flag_out     <= a_in ? flag_q : 8'd0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_stall_busy, clk_i, rst_ni, (state_q != S_IDLE) == in_stall_o, "stall mismatch")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_vld_q && out_stall_i, out_vld_q && $stable(out_q), "result lost")
  `ASSERT_ALWAYS(a_sp_range, clk_i, rst_ni, sp_q <= SpW'(NodeCount), "stack overflow")
endmodule

### rtl/grt_ram.sv
// generic single-port synchronous ram with registered read
module grt_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

### rtl/grt_walk_mem.sv
// visited map and walk stack memories used by the route walk
module grt_walk_mem (
  input  logic                     clk_i,
  input  grt_pkg::walk_req_t       req_i,
  output logic                     vis_rd_o,
  output logic [grt_pkg::NodeW-1:0] stk_rd_o
);
  import grt_pkg::*;

  grt_ram #(.Depth(NodeCount), .Width(1)) u_vis (
    .clk_i, .we_i(req_i.vis_we), .addr_i(req_i.vis_addr),
    .wdata_i(req_i.vis_wd), .rdata_o(vis_rd_o));

  grt_ram #(.Depth(NodeCount), .Width(NodeW)) u_stk (
    .clk_i, .we_i(req_i.stk_we), .addr_i(req_i.stk_addr),
    .wdata_i(req_i.stk_wd), .rdata_o(stk_rd_o));
endmodule
